// ----- rtl/core/vfdcd_pkg.sv -----
// Package for the display controller command decoder.
// Transfer structs, access and command codes, and RAM sizing.
// No dependencies.
`default_nettype none

package vfdcd_pkg;

	localparam int RAM_DEPTH = 32;
	localparam int KEY_BYTES = 3;
	localparam int RAM_AW = $clog2(RAM_DEPTH);
	localparam logic [5:0] RAM_LIMIT = 6'(RAM_DEPTH);
	localparam logic [1:0] KEY_LAST = 2'(KEY_BYTES - 1);

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_READ    = 2'd1,
		OP_KEYSCAN = 2'd2,
		OP_SCAN    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CLS_MODE = 2'd0,
		CLS_DATA = 2'd1,
		CLS_DISP = 2'd2,
		CLS_ADDR = 2'd3
	} cls_t;

	typedef enum logic [1:0] {
		TGT_DISPLAY = 2'd0,
		TGT_LED     = 2'd1,
		TGT_KEY     = 2'd2,
		TGT_SWITCH  = 2'd3
	} tgt_t;

	typedef struct packed {
		op_t         cmd;
		logic [7:0]  bus_byte;
		logic        frame_start;
		logic [23:0] key_matrix;
		logic [3:0]  switch_inputs;
		logic [4:0]  scan_address;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       read_valid;
		logic       display_enabled;
		logic [2:0] brightness_level;
		logic [2:0] grid_mode;
		logic [7:0] led_outputs;
	} rsp_t;

	typedef struct packed {
		logic       we;
		logic [4:0] waddr;
		logic [7:0] wdata;
		logic       rd;
		logic       rd_ok;
		logic [4:0] raddr;
	} ram_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/vfdcd_ram.sv -----
// Display RAM: one write and one registered read per cycle.
// Per-entry valid bits give the all-zero reset contents. Uses vfdcd_pkg.
`default_nettype none

module vfdcd_ram
	import vfdcd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ram_req_t   ram_req,
	output logic [7:0]      rdata_q,
	output logic            hit_q
);

	logic [7:0] mem [RAM_DEPTH];
	logic [RAM_DEPTH-1:0] entry_vld_q;

	always_ff @(posedge clk) begin
		if (ram_req.we) begin
			mem[ram_req.waddr[RAM_AW-1:0]] <= ram_req.wdata;
		end
		if (ram_req.rd && ram_req.rd_ok) begin
			rdata_q <= mem[ram_req.raddr[RAM_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (ram_req.we) begin
				entry_vld_q[ram_req.waddr[RAM_AW-1:0]] <= 1'b1;
			end
			if (ram_req.rd) begin
				hit_q <= ram_req.rd_ok && entry_vld_q[ram_req.raddr[RAM_AW-1:0]];
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/vfdcd_ctrl.sv -----
// Command decode and control registers: pointer, target, mode, dimming,
// LED, key and switch latches. Drives display RAM accesses. Uses vfdcd_pkg.
`default_nettype none

module vfdcd_ctrl
	import vfdcd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   accept,
	input  wire req_t   item,
	output ram_req_t    ram_req,
	output rsp_t        res,
	output logic        is_scan
);

	logic [4:0]  ptr_q, ptr_d;
	tgt_t        tgt_q, tgt_d;
	logic        fixed_q, fixed_d;
	logic [2:0]  mode_q, mode_d;
	logic        disp_on_q, disp_on_d;
	logic [2:0]  dim_q, dim_d;
	logic [7:0]  led_q, led_d;
	logic [23:0] key_q, key_d;
	logic [3:0]  sw_q, sw_d;
	logic [1:0]  kidx_q, kidx_d;
	logic [1:0]  kidx_sat;
	logic [7:0]  rd;
	logic        rv;

	assign kidx_sat = (kidx_q > KEY_LAST) ? KEY_LAST : kidx_q;

	always_comb begin
		ptr_d = ptr_q;
		tgt_d = tgt_q;
		fixed_d = fixed_q;
		mode_d = mode_q;
		disp_on_d = disp_on_q;
		dim_d = dim_q;
		led_d = led_q;
		key_d = key_q;
		sw_d = sw_q;
		kidx_d = kidx_q;
		rd = 8'd0;
		rv = 1'b0;
		is_scan = 1'b0;
		ram_req.we = 1'b0;
		ram_req.waddr = ptr_q;
		ram_req.wdata = item.bus_byte;
		ram_req.rd = 1'b0;
		ram_req.rd_ok = ({1'b0, item.scan_address} < RAM_LIMIT);
		ram_req.raddr = item.scan_address;
		unique case (item.cmd)
			OP_WRITE: begin
				if (item.frame_start) begin
					unique case (cls_t'(item.bus_byte[7:6]))
						CLS_MODE: mode_d = item.bus_byte[2:0];
						CLS_DATA: begin
							tgt_d = tgt_t'(item.bus_byte[1:0]);
							fixed_d = item.bus_byte[2];
							kidx_d = 2'd0;
						end
						CLS_DISP: begin
							disp_on_d = item.bus_byte[3];
							dim_d = item.bus_byte[2:0];
						end
						CLS_ADDR: ptr_d = item.bus_byte[4:0];
					endcase
				end else begin
					unique case (tgt_q)
						TGT_DISPLAY: begin
							ram_req.we = accept && ({1'b0, ptr_q} < RAM_LIMIT);
							if (!fixed_q) begin
								ptr_d = ptr_q + 5'd1;
							end
						end
						TGT_LED: led_d = item.bus_byte;
						TGT_KEY, TGT_SWITCH: ;
					endcase
				end
			end
			OP_READ: begin
				unique case (tgt_q)
					TGT_KEY: begin
						rd = key_q[{kidx_sat, 3'b000} +: 8];
						rv = 1'b1;
						kidx_d = (kidx_sat < KEY_LAST) ? kidx_sat + 2'd1 : kidx_sat;
					end
					TGT_SWITCH: begin
						rd = {4'd0, sw_q};
						rv = 1'b1;
					end
					TGT_DISPLAY, TGT_LED: ;
				endcase
			end
			OP_KEYSCAN: begin
				key_d = item.key_matrix;
				sw_d = item.switch_inputs;
			end
			OP_SCAN: begin
				is_scan = 1'b1;
				rv = ram_req.rd_ok;
				ram_req.rd = accept;
			end
		endcase
		res.read_data = rd;
		res.read_valid = rv;
		res.display_enabled = disp_on_d;
		res.brightness_level = dim_d;
		res.grid_mode = mode_d;
		res.led_outputs = led_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			tgt_q <= TGT_DISPLAY;
			fixed_q <= 1'b0;
			mode_q <= '0;
			disp_on_q <= 1'b0;
			dim_q <= '0;
			led_q <= '0;
			key_q <= '0;
			sw_q <= '0;
			kidx_q <= '0;
		end else if (accept) begin
			ptr_q <= ptr_d;
			tgt_q <= tgt_d;
			fixed_q <= fixed_d;
			mode_q <= mode_d;
			disp_on_q <= disp_on_d;
			dim_q <= dim_d;
			led_q <= led_d;
			key_q <= key_d;
			sw_q <= sw_d;
			kidx_q <= kidx_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/vfd_controller_command_decoder_core.sv -----
// Top level of the display controller command decoder.
// Instantiates vfdcd_ctrl and vfdcd_ram; uses vfdcd_pkg.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (req_t)
//   result  | rsp_valid | rsp_stall | rsp (rsp_t)
//
// One byte per cycle when not stalled; results come in the cycle after transfer.
// State updates and the display RAM write or read happen at request transfer;
// RAM read data is registered in the RAM and selected at the result register.
// Reset clears all control registers and the RAM entry valid bits at once.
// A stalled result holds the request side only while the result register is full.
`default_nettype none

module vfd_controller_command_decoder_core
	import vfdcd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	logic     accept;
	ram_req_t ram_req;
	rsp_t     res;
	logic     is_scan;
	logic [7:0] ram_rdata;
	logic     ram_hit;
	logic     valid_s1;
	rsp_t     rsp_s1;
	logic     scan_s1;

	assign req_stall = valid_s1 && rsp_stall;
	assign accept = req_valid && !req_stall;

	vfdcd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (req),
		.ram_req (ram_req),
		.res     (res),
		.is_scan (is_scan)
	);

	vfdcd_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.ram_req (ram_req),
		.rdata_q (ram_rdata),
		.hit_q   (ram_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_s1 <= res;
			scan_s1 <= is_scan;
		end
	end

	always_comb begin
		rsp = rsp_s1;
		if (scan_s1) begin
			rsp.read_data = ram_hit ? ram_rdata : 8'd0;
		end
	end

	assign rsp_valid = valid_s1;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted request produced no result");

	a_keyscan_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd == OP_KEYSCAN) |=> !rsp.read_valid)
		else $error("key scan sample returned read data");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.read_valid) |-> (rsp.read_data == 8'd0))
		else $error("read data nonzero without read_valid");

	a_write_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> !ram_req.rd)
		else $error("display RAM write and read in one transfer");

endmodule

`default_nettype wire
